// ===== hdl/lru_move_to_front_cache_top_assert.svh =====
// Assertion macros used by the lookup/update unit; clk and rst are taken from the scope of use.
`ifndef LRU_MOVE_TO_FRONT_CACHE_TOP_ASSERT_SVH
`define LRU_MOVE_TO_FRONT_CACHE_TOP_ASSERT_SVH

// Condition holds at every edge outside reset
`define LMTF_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("lru_mtf: invariant violated");

// Same-cycle implication
`define LMTF_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lru_mtf: implication violated");

// Next-cycle implication
`define LMTF_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lru_mtf: sequence violated");

`endif

// ===== hdl/lru_mtf_pkg.sv =====
package lru_mtf_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int KEY_W        = 16;
  localparam int VALUE_W      = 31;
  localparam int HANDLE_W     = 32;
  localparam int QUEUE_DEPTH  = 2;

  typedef struct packed {
    logic                operation;
    logic [KEY_W-1:0]    lookup_key;
    logic [VALUE_W-1:0]  entry_value;
    logic [HANDLE_W-1:0] entry_handle;
  } req_t;

  typedef struct packed {
    logic                hit;
    logic [VALUE_W-1:0]  found_value;
    logic [HANDLE_W-1:0] found_handle;
    logic                evicted;
    logic [HANDLE_W-1:0] evicted_handle;
  } rsp_t;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } op_kind_t;

  typedef struct packed {
    op_kind_t            kind;
    logic [KEY_W-1:0]    key;
    logic [VALUE_W-1:0]  value;
    logic [HANDLE_W-1:0] handle;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_LOOK = 3'b010,
    ST_UPD  = 3'b100
  } back_state_t;

endpackage

// ===== hdl/lru_mtf_front.sv =====
module lru_mtf_front import lru_mtf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic push_valid,
  output cmd_t push_cmd,
  input  logic queue_full
);

  logic hold_valid;
  cmd_t hold;
  cmd_t decoded;

  always_comb begin
    decoded.kind   = req.operation ? CMD_PUT : CMD_GET;
    decoded.key    = req.lookup_key;
    decoded.value  = req.entry_value;
    decoded.handle = req.entry_handle;
  end

  assign req_ready  = !hold_valid || !queue_full;
  assign push_valid = hold_valid;
  assign push_cmd   = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      hold_valid <= 1'b1;
    end else if (!queue_full) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      hold <= decoded;
    end
  end

endmodule

// ===== hdl/lru_mtf_queue.sv =====
module lru_mtf_queue import lru_mtf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic full,
  output logic pop_valid,
  output cmd_t pop_cmd,
  input  logic pop
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            entries [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            do_push;
  logic            do_pop;

  assign full      = fill == CntW'(QUEUE_DEPTH);
  assign pop_valid = fill != '0;
  assign pop_cmd   = entries[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== hdl/lru_mtf_back.sv =====
module lru_mtf_back import lru_mtf_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  back_state_t state;
  back_state_t state_next;
  cmd_t        cur;
  logic [CntW-1:0] count;

  logic [KEY_W-1:0]    slot_key    [CAPACITY];
  logic [VALUE_W-1:0]  slot_value  [CAPACITY];
  logic [HANDLE_W-1:0] slot_handle [CAPACITY];

  // lookup results, held from LOOK to UPD
  rsp_t                res;
  logic                wr_en;
  logic                inc;
  logic [CntW-1:0]     last;
  logic [VALUE_W-1:0]  front_value;
  logic [HANDLE_W-1:0] front_handle;

  logic [CAPACITY-1:0] match;
  logic [IdxW-1:0]     idx_sel;
  logic                found;
  logic                is_put;
  logic                full;
  logic [VALUE_W-1:0]  rd_value;
  logic [HANDLE_W-1:0] rd_handle;
  rsp_t                look_rsp;
  logic [CntW-1:0]     look_last;
  logic                commit;

  assign is_put = cur.kind == CMD_PUT;
  assign full   = count == CntW'(CAPACITY);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = (CntW'(i) < count) && (slot_key[i] == cur.key);
    end
  end

  // lowest matching slot is the most recent
  always_comb begin
    idx_sel = '0;
    found   = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        idx_sel = IdxW'(i);
        found   = 1'b1;
      end
    end
  end

  assign rd_value  = slot_value[idx_sel];
  assign rd_handle = slot_handle[idx_sel];

  always_comb begin
    look_rsp.hit          = found;
    look_rsp.found_value  = (!is_put && found) ? rd_value : '0;
    look_rsp.found_handle = (!is_put && found) ? rd_handle : '0;
    look_rsp.evicted      = is_put && !found && full;
    if (is_put && found) begin
      look_rsp.evicted_handle = rd_handle;
    end else if (look_rsp.evicted) begin
      look_rsp.evicted_handle = slot_handle[CAPACITY-1];
    end else begin
      look_rsp.evicted_handle = '0;
    end
    if (found) begin
      look_last = CntW'(idx_sel);
    end else if (full) begin
      look_last = CntW'(CAPACITY - 1);
    end else begin
      look_last = count;
    end
  end

  assign commit  = (state == ST_UPD) && (!rsp_valid || rsp_ready);
  assign cmd_pop = cmd_valid && ((state == ST_IDLE) || commit);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (cmd_valid) state_next = ST_LOOK;
      ST_LOOK: state_next = ST_UPD;
      ST_UPD: begin
        if (commit) state_next = cmd_valid ? ST_LOOK : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit && inc) begin
        count <= count + 1'b1;
      end
      if (commit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur <= cmd;
    end
    if (state == ST_LOOK) begin
      res          <= look_rsp;
      wr_en        <= found || is_put;
      inc          <= is_put && !found && !full;
      last         <= look_last;
      front_value  <= is_put ? cur.value : rd_value;
      front_handle <= is_put ? cur.handle : rd_handle;
    end
    if (commit) begin
      rsp <= res;
    end
  end

  // one-step shift toward the back over slots up to last, new entry at the front
  always_ff @(posedge clk) begin
    if (commit && wr_en) begin
      for (int i = 1; i < CAPACITY; i++) begin
        if (CntW'(i) <= last) begin
          slot_key[i]    <= slot_key[i-1];
          slot_value[i]  <= slot_value[i-1];
          slot_handle[i] <= slot_handle[i-1];
        end
      end
      slot_key[0]    <= cur.key;
      slot_value[0]  <= front_value;
      slot_handle[0] <= front_handle;
    end
  end

`include "lru_move_to_front_cache_top_assert.svh"

  `LMTF_ALWAYS(a_count_bound, count <= CntW'(CAPACITY))
  `LMTF_NEXT(a_look_to_upd, state == ST_LOOK, state == ST_UPD)
  `LMTF_NEXT(a_count_grows, commit && inc, count == $past(count) + 1'b1)
  `LMTF_IMPLIES(a_evict_is_miss, rsp_valid && rsp.evicted, !rsp.hit)

endmodule

// ===== hdl/lru_move_to_front_cache_top.sv =====
// Channel | Handshake           | Payload | Carries
// req     | req_valid/req_ready | req_t   | get or put: key, value, handle
// rsp     | rsp_valid/rsp_ready | rsp_t   | hit, found value/handle, eviction
//
// The lookup/update unit takes each item through LOOK, a compare of every slot in
// parallel, then UPD, a one-slot shift toward the back with the entry written at
// slot 0. It starts the next item only when UPD commits, which waits while rsp stalls.
// A two-entry queue between front and back buffers req while rsp stalls, until full.
// Reset clears the entry count and all handshake state; slot contents are kept.
module lru_move_to_front_cache_top import lru_mtf_pkg::*; #(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic push_valid;
  cmd_t push_cmd;
  logic queue_full;
  logic pop_valid;
  cmd_t pop_cmd;
  logic pop;

  lru_mtf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .queue_full (queue_full)
  );

  lru_mtf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .full       (queue_full),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop        (pop)
  );

  lru_mtf_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd       (pop_cmd),
    .cmd_pop   (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== tb/tb_lru_move_to_front_cache_top.sv =====
module tb_lru_move_to_front_cache_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lru_mtf_pkg::*;

  localparam int SLOTS = DEF_CAPACITY;

  typedef struct {
    req_t item;
    bit   drain;
  } queued_req_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  queued_req_t pending_reqs[$];
  rsp_t        expected_rsp[$];
  rsp_t        oldest_rsp;
  int          errors = 0;
  int          cycle_no = 0;

  // model copy of the recency-ordered store, slot 0 most recent
  logic [KEY_W-1:0]    model_key[SLOTS];
  logic [VALUE_W-1:0]  model_value[SLOTS];
  logic [HANDLE_W-1:0] model_handle[SLOTS];
  int                  model_used = 0;

  lru_move_to_front_cache_top DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always #2 clk = ~clk;

  always @(posedge clk) cycle_no <= cycle_no + 1;

  // no idling in a quiet window part way through the run
  function automatic bit take_break();
    if (cycle_no >= 1000 && cycle_no < 2000) return 1'b0;
    return $urandom_range(99) < 10;
  endfunction

  // drop slot `last` (or free it), shift [0, last-1] back and write the front
  function automatic void promote_entry(int last, logic [KEY_W-1:0] k,
                                        logic [VALUE_W-1:0] v, logic [HANDLE_W-1:0] h);
    for (int i = last; i > 0; i--) begin
      model_key[i]    = model_key[i-1];
      model_value[i]  = model_value[i-1];
      model_handle[i] = model_handle[i-1];
    end
    model_key[0]    = k;
    model_value[0]  = v;
    model_handle[0] = h;
  endfunction

  function automatic rsp_t cache_access(req_t r);
    rsp_t o;
    int   idx;
    o   = '0;
    idx = -1;
    for (int i = 0; i < model_used; i++)
      if (idx < 0 && model_key[i] == r.lookup_key) idx = i;
    if (op_kind_t'(r.operation) == CMD_GET) begin
      if (idx >= 0) begin
        o.hit          = 1'b1;
        o.found_value  = model_value[idx];
        o.found_handle = model_handle[idx];
        promote_entry(idx, r.lookup_key, o.found_value, o.found_handle);
      end
    end else if (idx >= 0) begin
      o.hit            = 1'b1;
      o.evicted_handle = model_handle[idx];
      promote_entry(idx, r.lookup_key, r.entry_value, r.entry_handle);
    end else if (model_used < SLOTS) begin
      promote_entry(model_used, r.lookup_key, r.entry_value, r.entry_handle);
      model_used++;
    end else begin
      o.evicted        = 1'b1;
      o.evicted_handle = model_handle[SLOTS-1];
      promote_entry(SLOTS - 1, r.lookup_key, r.entry_value, r.entry_handle);
    end
    return o;
  endfunction

  function automatic void queue_req(op_kind_t op, logic [KEY_W-1:0] k,
                                    logic [VALUE_W-1:0] v, logic [HANDLE_W-1:0] h,
                                    bit drain = 1'b0);
    queued_req_t q;
    q.item.operation    = op;
    q.item.lookup_key   = k;
    q.item.entry_value  = v;
    q.item.entry_handle = h;
    q.drain             = drain;
    pending_reqs.push_back(q);
  endfunction

  task automatic check_field(string field, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp, act);
    end
  endtask

  // request driver; the expected response is predicted at acceptance
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) expected_rsp.push_back(cache_access(req));
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() != 0 && !take_break() &&
            !(pending_reqs[0].drain && expected_rsp.size() != 0)) begin
          req       <= pending_reqs[0].item;
          req_valid <= 1'b1;
          void'(pending_reqs.pop_front());
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          errors++;
          $display("%0t: response with nothing outstanding, expected none, actual %p",
                   $time, rsp);
        end else begin
          oldest_rsp = expected_rsp.pop_front();
          check_field("hit", oldest_rsp.hit, rsp.hit);
          check_field("found_value", oldest_rsp.found_value, rsp.found_value);
          check_field("found_handle", oldest_rsp.found_handle, rsp.found_handle);
          check_field("evicted", oldest_rsp.evicted, rsp.evicted);
          check_field("evicted_handle", oldest_rsp.evicted_handle, rsp.evicted_handle);
        end
      end
      rsp_ready <= !take_break();
    end
  end

  initial begin
    logic [KEY_W-1:0] key_pool[40];
    int               pool_sizes[6];
    logic [KEY_W-1:0] k;
    op_kind_t         op;

    pool_sizes = '{4, 12, 18, 24, 40, 16};
    foreach (key_pool[i]) key_pool[i] = $urandom_range(0, 65535);

    // directed: empty miss, field extremes, front update, promotion, fill and evict
    queue_req(CMD_GET, 16'h0000, '1, '1);
    queue_req(CMD_PUT, 16'h0000, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    queue_req(CMD_PUT, 16'hFFFF, '0, '0);
    queue_req(CMD_PUT, 16'hFFFF, 31'h5555_5555, 32'hAAAA_AAAA);
    queue_req(CMD_GET, 16'h0000, '0, '0);
    queue_req(CMD_GET, 16'h0000, 31'h2AAA_AAAA, 32'h5555_5555);
    for (int i = 1; i <= 14; i++)
      queue_req(CMD_PUT, KEY_W'(i), VALUE_W'(i * 1000), HANDLE_W'(32'h1000_0000 + i));
    queue_req(CMD_PUT, 16'd100, 31'h1234_5678, 32'hDEAD_BEEF);   // full: LRU dropped
    queue_req(CMD_GET, 16'hFFFF, '0, '0);                         // evicted key misses
    queue_req(CMD_PUT, 16'h0000, 31'h0000_0001, 32'h8000_0000);   // hit in last slot
    queue_req(CMD_GET, 16'd7, 31'h7FFF_FFFF, 32'hFFFF_FFFF);      // hit mid-list

    for (int phase = 0; phase < 6; phase++) begin
      for (int n = 0; n < 225; n++) begin
        if ($urandom_range(9) == 0) k = $urandom_range(0, 65535);
        else k = key_pool[$urandom_range(pool_sizes[phase] - 1)];
        op = ($urandom_range(1) != 0) ? CMD_PUT : CMD_GET;
        queue_req(op, k, VALUE_W'($urandom), $urandom, n == 0);
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || req_valid || expected_rsp.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

endmodule
